>>> rtl/bdcc_pkg.sv
// shared types and constants for the button debounce and click counter
// no dependencies; used by the interfaces and every module under rtl
package bdcc_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int TIME_W      = 32;
	localparam int LEVELS_W    = 8;
	localparam int CNT_W       = 8;
	localparam int COUNTS_W    = 64;
	localparam int MS_W        = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [MS_W-1:0] DEBOUNCE_RST  = MS_W'(50);
	localparam logic [MS_W-1:0] CLICK_GAP_RST = MS_W'(350);
	localparam logic            PRESSED_RST   = 1'b1;
	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE  = 2'd0,
		REG_CLICK_GAP = 2'd1,
		REG_PRESSED   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MS_W-1:0] debounce_ms;
		logic [MS_W-1:0] click_gap_ms;
		logic            pressed_level;
	} cfg_t;

	typedef struct packed {
		logic             evt_req;
		logic [CNT_W-1:0] cnt_post;
		logic             cnt_zero;
	} lane_st_t;

endpackage

>>> rtl/bdcc_poll_if.sv
// poll channel: timestamp and button levels with valid/ready
// depends on bdcc_pkg
interface bdcc_poll_if;
	import bdcc_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   now_ms;
	logic [LEVELS_W-1:0] button_levels;

	modport source (output valid, output now_ms, output button_levels, input ready);
	modport sink (input valid, input now_ms, input button_levels, output ready);

endinterface

>>> rtl/bdcc_res_if.sv
// result channel: event flag and packed click counts with valid/ready
// depends on bdcc_pkg
interface bdcc_res_if;
	import bdcc_pkg::*;

	logic                valid;
	logic                ready;
	logic                event_res;
	logic [COUNTS_W-1:0] click_counts;

	modport source (output valid, output event_res, output click_counts, input ready);
	modport sink (input valid, input event_res, input click_counts, output ready);

endinterface

>>> rtl/bdcc_cfg_if.sv
// configuration write channel: register index and data with valid/ready
// depends on bdcc_pkg
interface bdcc_cfg_if;
	import bdcc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

>>> rtl/bdcc_cfg_regs.sv
// configuration registers: debounce time, click gap and pressed level
// depends on bdcc_pkg and bdcc_cfg_if
module bdcc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	bdcc_cfg_if.sink      cfg,
	output bdcc_pkg::cfg_t cfg_val
);
	import bdcc_pkg::*;

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.click_gap_ms  <= CLICK_GAP_RST;
			cfg_q.pressed_level <= PRESSED_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DEBOUNCE:  cfg_q.debounce_ms   <= MS_W'(cfg.data);
				REG_CLICK_GAP: cfg_q.click_gap_ms  <= MS_W'(cfg.data);
				REG_PRESSED:   cfg_q.pressed_level <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/bdcc_lane.sv
// one button: stored level, last press time and click count
// depends on bdcc_pkg
module bdcc_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  logic                      evt,
	input  logic [bdcc_pkg::TIME_W-1:0] now_ms,
	input  logic                      level,
	input  bdcc_pkg::cfg_t            cfg_val,
	output bdcc_pkg::lane_st_t        st
);
	import bdcc_pkg::*;

	logic              last_level_q;
	logic [TIME_W-1:0] press_time_q;
	logic [CNT_W-1:0]  count_q;

	logic [TIME_W-1:0] elapsed;
	logic              examined;
	logic              changed;
	logic              press;

	// wraps modulo 2^32
	assign elapsed  = now_ms - press_time_q;
	assign examined = elapsed > TIME_W'(cfg_val.debounce_ms);
	assign changed  = examined && (level != last_level_q);
	assign press    = changed && (level == cfg_val.pressed_level);

	always_comb begin
		st.evt_req  = examined && !changed && (count_q != '0)
			&& (elapsed > TIME_W'(cfg_val.click_gap_ms));
		st.cnt_post = (press && count_q != CNT_MAX) ? count_q + CNT_W'(1) : count_q;
		st.cnt_zero = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= PRESSED_RST;
			press_time_q <= '0;
			count_q      <= '0;
		end else if (upd) begin
			if (changed)
				last_level_q <= level;
			if (press)
				press_time_q <= now_ms;
			count_q <= evt ? '0 : st.cnt_post;
		end
	end

endmodule

>>> rtl/button_debounce_click_counter_core.sv
// top level of the button debounce and click counter; uses bdcc_pkg, the channel
// interfaces, bdcc_cfg_regs and bdcc_lane
// pipeline: poll words go through the input stage, then the result register
// throughput: one poll word per cycle unless stalled; all buttons in parallel lanes
// reset: asynchronous, clears the pipeline and restores register and button defaults
module button_debounce_click_counter_core (
	input  logic      clk,
	input  logic      arst_n,
	bdcc_poll_if.sink poll,
	bdcc_res_if.source res,
	bdcc_cfg_if.sink  cfg
);
	import bdcc_pkg::*;

	cfg_t              cfg_val;
	lane_st_t          lane_st [NUM_BUTTONS];

	logic                valid_s1;
	logic [TIME_W-1:0]   now_ms_s1;
	logic [LEVELS_W-1:0] levels_s1;

	logic                out_valid_q;
	logic                event_q;
	logic [COUNTS_W-1:0] counts_q;

	logic                advance;
	logic                evt;
	logic [COUNTS_W-1:0] counts_d;

	assign advance    = valid_s1 && (!out_valid_q || res.ready);
	assign poll.ready = !valid_s1 || advance;

	bdcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bdcc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.upd     (advance),
			.evt     (evt),
			.now_ms  (now_ms_s1),
			.level   (levels_s1[g]),
			.cfg_val (cfg_val),
			.st      (lane_st[g])
		);
	end

	always_comb begin
		evt = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			evt = evt | lane_st[i].evt_req;
		counts_d = '0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			counts_d[i*CNT_W +: CNT_W] = evt ? lane_st[i].cnt_post : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.valid && poll.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			now_ms_s1 <= poll.now_ms;
			levels_s1 <= poll.button_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q  <= evt;
			counts_q <= counts_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.event_res    = event_q;
	assign res.click_counts = counts_q;

	logic all_cnt_zero;
	always_comb begin
		all_cnt_zero = 1'b1;
		for (int i = 0; i < NUM_BUTTONS; i++)
			all_cnt_zero = all_cnt_zero & lane_st[i].cnt_zero;
	end

`ifndef SYNTHESIS
	// a report word never goes out empty, a quiet word never carries counts
	a_evt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q |-> counts_q != '0)
		else $error("event word with all counts zero");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !event_q |-> counts_q == '0)
		else $error("non-event word with counts");

	// counts are cleared once a report is taken into the result register
	a_clear_after_evt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt |=> all_cnt_zero)
		else $error("counts not cleared after event");

	// the poll side stalls only when both stages are full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!poll.ready |-> valid_s1 && out_valid_q && !res.ready)
		else $error("poll stalled without back-pressure");
`endif

endmodule

>>> tb/bdcc_click_checker.sv
// scoreboard for the button debounce and click counter: predicts every result word
// from the poll and configuration words it sees and compares it with the block's output
// depends on bdcc_pkg and the channel interfaces
`timescale 1ns / 1ps

module bdcc_click_checker (
	input  logic  clk,
	input  logic  arst_n,
	bdcc_poll_if  poll,
	bdcc_res_if   res,
	bdcc_cfg_if   cfg,
	output int    errors,
	output int    pending
);
	import bdcc_pkg::*;

	typedef struct packed {
		logic                evt;
		logic [COUNTS_W-1:0] counts;
	} report_t;

	cfg_t             cfg_now;
	logic             held_lvl [NUM_BUTTONS];
	logic [TIME_W-1:0] press_ts [NUM_BUTTONS];
	logic [CNT_W-1:0] clicks   [NUM_BUTTONS];
	report_t          expected_reports [$];
	report_t          exp_rep;

	// one poll against the button state; updates levels, counts and press times
	function automatic report_t predict_report(input logic [TIME_W-1:0] now,
			input logic [LEVELS_W-1:0] levels);
		report_t           rep;
		logic [TIME_W-1:0] since;
		logic              fire;
		rep = '0;
		fire = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			// elapsed time wraps with the timestamp
			since = now - press_ts[i];
			if (since > TIME_W'(cfg_now.debounce_ms)) begin
				if (levels[i] != held_lvl[i]) begin
					held_lvl[i] = levels[i];
					if (levels[i] == cfg_now.pressed_level) begin
						if (clicks[i] != CNT_MAX)
							clicks[i] = clicks[i] + 1'b1;
						press_ts[i] = now;
					end
				end else if (clicks[i] != '0 && since > TIME_W'(cfg_now.click_gap_ms)) begin
					fire = 1'b1;
				end
			end
		end
		if (fire) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				rep.counts[i*CNT_W +: CNT_W] = clicks[i];
				clicks[i] = '0;
			end
		end
		rep.evt = fire;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_now.debounce_ms = DEBOUNCE_RST;
			cfg_now.click_gap_ms = CLICK_GAP_RST;
			cfg_now.pressed_level = PRESSED_RST;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				held_lvl[i] = PRESSED_RST;
				press_ts[i] = '0;
				clicks[i] = '0;
			end
			expected_reports.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEBOUNCE: cfg_now.debounce_ms = cfg.data;
					REG_CLICK_GAP: cfg_now.click_gap_ms = cfg.data;
					REG_PRESSED: cfg_now.pressed_level = cfg.data[0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (expected_reports.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected: event %0b counts %h",
						$time, res.event_res, res.click_counts);
				end else begin
					exp_rep = expected_reports.pop_front();
					if (res.event_res !== exp_rep.evt) begin
						errors++;
						$display("%0t: event_res expected %0b got %0b",
							$time, exp_rep.evt, res.event_res);
					end
					if (res.click_counts !== exp_rep.counts) begin
						errors++;
						$display("%0t: click_counts expected %h got %h",
							$time, exp_rep.counts, res.click_counts);
					end
				end
			end
			if (poll.valid && poll.ready)
				expected_reports.push_back(predict_report(poll.now_ms, poll.button_levels));
			pending <= expected_reports.size();
		end
	end

endmodule

>>> tb/button_debounce_click_counter_core_tb.sv
// testbench top for button_debounce_click_counter_core: drives poll and register words,
// throttles the result side and reports the verdict; checking is in bdcc_click_checker
// depends on bdcc_pkg, the channel interfaces, the core and the checker
`timescale 1ns / 1ps

module button_debounce_click_counter_core_tb;
	import bdcc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	bdcc_poll_if poll_ch ();
	bdcc_res_if  res_ch ();
	bdcc_cfg_if  cfg_ch ();

	int errors;
	int pending;
	int quiet_cycles = 0;
	int tx_pct;
	int rx_pct;
	logic hold_req;
	int db_now;
	int gap_now;
	logic [TIME_W-1:0]   t_now;
	logic [LEVELS_W-1:0] lv_now;

	button_debounce_click_counter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	bdcc_click_checker click_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_ch),
		.res     (res_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rx_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("button_debounce_click_counter_core_tb: FAIL");
		$finish;
	end

	task automatic send_poll(input logic [TIME_W-1:0] t, input logic [LEVELS_W-1:0] lv);
		poll_ch.valid <= 1'b1;
		poll_ch.now_ms <= t;
		poll_ch.button_levels <= lv;
		@(posedge clk);
		while (!poll_ch.ready) @(posedge clk);
		if ($urandom_range(99) < tx_pct) begin
			poll_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_pct);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// one edge first so the last accepted poll word is counted
	task automatic wait_drained;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_regs(input int db, input int gap, input logic pl);
		wait_drained();
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(db));
		write_reg(REG_CLICK_GAP, CFG_DATA_W'(gap));
		write_reg(REG_PRESSED, {15'($urandom), pl});
		// unknown index, must leave every register alone
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
		db_now = db;
		gap_now = gap;
	endtask

	// mostly steady time steps around the thresholds, with some wild timestamps
	task automatic run_random(input int n);
		int r;
		int span;
		logic [TIME_W-1:0] step;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				t_now = $urandom;
				lv_now = LEVELS_W'($urandom);
			end else begin
				span = (db_now > gap_now) ? db_now : gap_now;
				r = $urandom_range(99);
				if (r < 10)
					step = db_now;
				else if (r < 20)
					step = db_now + 1;
				else if (r < 28)
					step = gap_now;
				else if (r < 36)
					step = gap_now + 1;
				else if (r < 92)
					step = $urandom_range(span / 4 + 3);
				else
					step = $urandom_range(2 * span + 8);
				t_now = t_now + step;
				lv_now = lv_now ^ LEVELS_W'($urandom & $urandom);
			end
			send_poll(t_now, lv_now);
		end
		poll_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		poll_ch.valid <= 1'b0;
		poll_ch.now_ms <= '0;
		poll_ch.button_levels <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_DEBOUNCE;
		cfg_ch.data <= '0;
		tx_pct = 0;
		rx_pct = 0;
		hold_req = 1'b0;
		db_now = DEBOUNCE_RST;
		gap_now = CLICK_GAP_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: debounce boundary, release, all pressed, gap boundary, report
		send_poll(32'd0, 8'h00);
		send_poll(32'd50, 8'h00);
		send_poll(32'd51, 8'h00);
		send_poll(32'd52, 8'hFF);
		send_poll(32'd102, 8'h00);
		send_poll(32'd103, 8'h00);
		send_poll(32'd104, 8'h01);
		send_poll(32'd402, 8'h01);
		send_poll(32'd403, 8'h01);
		// press just before the timestamp wraps, report just after
		send_poll(32'hFFFF_FFF0, 8'h00);
		send_poll(32'hFFFF_FFFF, 8'h80);
		send_poll(32'h0000_0031, 8'h00);
		send_poll(32'h0000_0032, 8'h00);
		send_poll(32'h0000_015E, 8'h00);
		send_poll(32'h0000_015E, 8'h55);
		send_poll(32'h0000_0200, 8'hAA);
		poll_ch.valid <= 1'b0;
		t_now = 32'h0000_0200;
		lv_now = 8'hAA;

		set_regs(0, 0, 1'b1);
		run_random(120);

		// pressed level low: stored levels keep their old meaning
		set_regs(5, 40, 1'b0);
		tx_pct = 56;
		run_random(220);

		set_regs(3, 25, 1'b1);
		tx_pct = 0;
		rx_pct = 56;
		hold_req = 1'b1;
		run_random(220);

		set_regs($urandom_range(20), $urandom_range(100), 1'($urandom));
		tx_pct = 32;
		rx_pct = 32;
		run_random(220);

		// hammer every button past the count limit, then let the gap expire
		set_regs(0, 65535, 1'b1);
		tx_pct = 0;
		rx_pct = 0;
		for (int k = 0; k < 520; k++) begin
			t_now = t_now + 1;
			lv_now = k[0] ? 8'hFF : 8'h00;
			send_poll(t_now, lv_now);
		end
		t_now = t_now + 32'd70000;
		send_poll(t_now, lv_now);
		poll_ch.valid <= 1'b0;

		set_regs(65535, 0, 1'b1);
		tx_pct = 56;
		run_random(120);

		set_regs($urandom_range(65535), $urandom_range(65535), 1'($urandom));
		tx_pct = 0;
		rx_pct = 56;
		run_random(80);

		set_regs(65535, 65535, 1'b0);
		tx_pct = 32;
		rx_pct = 32;
		run_random(60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("button_debounce_click_counter_core_tb: PASS");
		else
			$display("button_debounce_click_counter_core_tb: FAIL");
		$finish;
	end

endmodule
